/* src/cylinder_window_segment_clipper_core_macros.svh */
// assertion macros shared by the clipper modules
`ifndef CYLINDER_WINDOW_SEGMENT_CLIPPER_CORE_MACROS_SVH
`define CYLINDER_WINDOW_SEGMENT_CLIPPER_CORE_MACROS_SVH

// same-cycle implication
`define CWSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CWSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cwsc_pkg.sv */
// types and constants shared by the segment clipper modules
package cwsc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_EDGES   = 4;
  localparam int NUM_COORDS  = 4;
  localparam int T_FRAC      = 16;
  localparam int T_W         = T_FRAC + 2;

  localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC);
  localparam logic [T_W-1:0] T_SAT = T_W'((1 << T_FRAC) + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RPHI_LOW,
    REG_RPHI_HIGH,
    REG_HALF_LENGTH_Z,
    REG_RPHI_MIDDLE,
    REG_PI_TIMES_RADIUS,
    REG_FULL_CIRCLE,
    REG_BOUNDS_ARE_CYLINDER
  } reg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_OUTSIDE,
    STATUS_NOT_CYL
  } status_t;

  typedef struct packed {
    logic [31:0] rphi_low;
    logic [31:0] rphi_high;
    logic [30:0] half_length_z;
    logic [31:0] rphi_middle;
    logic [29:0] pi_times_radius;
    logic        full_circle;
    logic        bounds_are_cylinder;
  } cfg_t;

  typedef struct packed {
    logic entry;
    logic leave;
    logic bad;
    logic over;
    logic equal;
  } edge_ctl_t;

  typedef struct packed {
    logic                           not_cyl;
    edge_ctl_t [NUM_EDGES-1:0]      edges;
  } item_ctl_t;

endpackage

/* src/cwsc_cfg_regs.sv */
// configuration register file of the segment clipper
module cwsc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cwsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cwsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output cwsc_pkg::cfg_t                      cfg
);
  import cwsc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{bounds_are_cylinder: 1'b1, default: '0};
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_RPHI_LOW:            cfg.rphi_low <= cfg_data;
        REG_RPHI_HIGH:           cfg.rphi_high <= cfg_data;
        REG_HALF_LENGTH_Z:       cfg.half_length_z <= cfg_data[30:0];
        REG_RPHI_MIDDLE:         cfg.rphi_middle <= cfg_data;
        REG_PI_TIMES_RADIUS:     cfg.pi_times_radius <= cfg_data[29:0];
        REG_FULL_CIRCLE:         cfg.full_circle <= cfg_data[0];
        REG_BOUNDS_ARE_CYLINDER: cfg.bounds_are_cylinder <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* src/cwsc_setup.sv */
// front stages: unwrap, edge terms and divider operands
module cwsc_setup #(
  parameter int COORD_WIDTH = 32,
  localparam int BASE_W = (COORD_WIDTH > 32) ? COORD_WIDTH : 32,
  localparam int XW = BASE_W + 2,
  localparam int DW = XW + 1,
  localparam int SIDE_W = 2 * XW + 2 * DW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] start_rphi,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] end_rphi,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  input  cwsc_pkg::cfg_t                cfg,
  output logic                          out_valid,
  output cwsc_pkg::item_ctl_t           out_ctl,
  output logic [DW-1:0]                 out_rem [cwsc_pkg::NUM_EDGES],
  output logic [DW-1:0]                 out_den [cwsc_pkg::NUM_EDGES],
  output logic [SIDE_W-1:0]             out_side
);
  import cwsc_pkg::*;

  logic signed [XW-1:0] mid, pr, two_pr;
  logic signed [DW-1:0] low, high, hz;

  assign mid    = XW'($signed(cfg.rphi_middle));
  assign pr     = XW'($signed({1'b0, cfg.pi_times_radius}));
  assign two_pr = pr <<< 1;
  assign low    = DW'($signed(cfg.rphi_low));
  assign high   = DW'($signed(cfg.rphi_high));
  assign hz     = DW'($signed({1'b0, cfg.half_length_z}));

  // stage 1: input capture
  logic                 s1_valid, s1_nc;
  logic signed [XW-1:0] s1_x0, s1_y0, s1_x1, s1_y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x0 <= XW'(start_rphi);
      s1_y0 <= XW'(start_z);
      s1_x1 <= XW'(end_rphi);
      s1_y1 <= XW'(end_z);
      s1_nc <= !cfg.bounds_are_cylinder;
    end
  end

  // stage 2: unwrap downward
  logic                 s2_valid, s2_nc;
  logic signed [XW-1:0] s2_x0, s2_y0, s2_x1, s2_y1;
  logic signed [XW-1:0] dn_x0, dn_x1;

  always_comb begin
    dn_x0 = s1_x0;
    dn_x1 = s1_x1;
    if (!cfg.full_circle && ((s1_x0 - mid) > pr)) begin
      dn_x0 = s1_x0 - two_pr;
    end
    if (!cfg.full_circle && ((s1_x1 - mid) > pr)) begin
      dn_x1 = s1_x1 - two_pr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_x0 <= dn_x0;
      s2_x1 <= dn_x1;
      s2_y0 <= s1_y0;
      s2_y1 <= s1_y1;
      s2_nc <= s1_nc;
    end
  end

  // stage 3: unwrap upward
  logic                 s3_valid, s3_nc;
  logic signed [XW-1:0] s3_x0, s3_y0, s3_x1, s3_y1;
  logic signed [XW-1:0] up_x0, up_x1;

  always_comb begin
    up_x0 = s2_x0;
    up_x1 = s2_x1;
    if (!cfg.full_circle && ((mid - s2_x0) > pr)) begin
      up_x0 = s2_x0 + two_pr;
    end
    if (!cfg.full_circle && ((mid - s2_x1) > pr)) begin
      up_x1 = s2_x1 + two_pr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_x0 <= up_x0;
      s3_x1 <= up_x1;
      s3_y0 <= s2_y0;
      s3_y1 <= s2_y1;
      s3_nc <= s2_nc;
    end
  end

  // stage 4: direction and distances to the window edges (low and high r-phi, both z ends)
  logic                 s4_valid, s4_nc;
  logic signed [DW-1:0] s4_p [NUM_EDGES];
  logic signed [DW-1:0] s4_q [NUM_EDGES];
  logic [SIDE_W-1:0]    s4_side;
  logic signed [DW-1:0] dx_w, dy_w;

  assign dx_w = DW'(s3_x1) - DW'(s3_x0);
  assign dy_w = DW'(s3_y1) - DW'(s3_y0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_p[0] <= -dx_w;
      s4_q[0] <= DW'(s3_x0) - low;
      s4_p[1] <= dx_w;
      s4_q[1] <= high - DW'(s3_x0);
      s4_p[2] <= -dy_w;
      s4_q[2] <= DW'(s3_y0) + hz;
      s4_p[3] <= dy_w;
      s4_q[3] <= hz - DW'(s3_y0);
      s4_side <= {s3_x0, s3_y0, dx_w, dy_w};
      s4_nc <= s3_nc;
    end
  end

  // stage 5: classify each edge, magnitudes
  logic              s5_valid;
  item_ctl_t         s5_ctl, ctl5;
  logic [DW-1:0]     s5_a [NUM_EDGES];
  logic [DW-1:0]     s5_b [NUM_EDGES];
  logic [DW-1:0]     a5 [NUM_EDGES];
  logic [DW-1:0]     b5 [NUM_EDGES];
  logic [SIDE_W-1:0] s5_side;

  always_comb begin
    ctl5 = '0;
    ctl5.not_cyl = s4_nc;
    for (int i = 0; i < NUM_EDGES; i++) begin
      // r-phi edges drop out on a closed cylinder
      if (!(cfg.full_circle && i < 2)) begin
        ctl5.edges[i].entry = (s4_p[i] < 0) && (s4_q[i] < 0);
        ctl5.edges[i].leave = (s4_p[i] > 0) && (s4_q[i] >= 0);
        ctl5.edges[i].bad   = (s4_p[i] >= 0) && (s4_q[i] < 0);
      end
      a5[i] = (s4_q[i] < 0) ? -s4_q[i] : s4_q[i];
      b5[i] = (s4_p[i] < 0) ? -s4_p[i] : s4_p[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (advance) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_ctl <= ctl5;
      s5_a <= a5;
      s5_b <= b5;
      s5_side <= s4_side;
    end
  end

  // stage 6: saturation compare and first remainder
  item_ctl_t ctl6;

  always_comb begin
    ctl6 = s5_ctl;
    for (int i = 0; i < NUM_EDGES; i++) begin
      ctl6.edges[i].over  = s5_a[i] >= s5_b[i];
      ctl6.edges[i].equal = s5_a[i] == s5_b[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ctl <= ctl6;
      out_side <= s5_side;
      for (int i = 0; i < NUM_EDGES; i++) begin
        out_rem[i] <= ctl6.edges[i].over ? '0 : s5_a[i];
        out_den[i] <= s5_b[i];
      end
    end
  end

endmodule

/* src/cwsc_div_pipe.sv */
// pipelined fractional divider, one quotient bit per stage, four lanes
`include "cylinder_window_segment_clipper_core_macros.svh"
module cwsc_div_pipe #(
  parameter int COORD_WIDTH = 32,
  localparam int BASE_W = (COORD_WIDTH > 32) ? COORD_WIDTH : 32,
  localparam int XW = BASE_W + 2,
  localparam int DW = XW + 1,
  localparam int SIDE_W = 2 * XW + 2 * DW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  cwsc_pkg::item_ctl_t               in_ctl,
  input  logic [DW-1:0]                     in_rem [cwsc_pkg::NUM_EDGES],
  input  logic [DW-1:0]                     in_den [cwsc_pkg::NUM_EDGES],
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output cwsc_pkg::item_ctl_t               out_ctl,
  output logic [cwsc_pkg::T_FRAC-1:0]       out_quo [cwsc_pkg::NUM_EDGES],
  output logic [cwsc_pkg::NUM_EDGES-1:0]    out_rem_nz,
  output logic [SIDE_W-1:0]                 out_side
);
  import cwsc_pkg::*;

  logic              st_valid [T_FRAC];
  item_ctl_t         st_ctl   [T_FRAC];
  logic [SIDE_W-1:0] st_side  [T_FRAC];
  logic [DW-1:0]     st_rem   [T_FRAC][NUM_EDGES];
  logic [DW-1:0]     st_den   [T_FRAC][NUM_EDGES];
  logic [T_FRAC-1:0] st_quo   [T_FRAC][NUM_EDGES];

  for (genvar k = 0; k < T_FRAC; k++) begin : g_stage
    logic              src_valid;
    item_ctl_t         src_ctl;
    logic [SIDE_W-1:0] src_side;
    logic [DW-1:0]     src_rem [NUM_EDGES];
    logic [DW-1:0]     src_den [NUM_EDGES];
    logic [T_FRAC-1:0] src_quo [NUM_EDGES];
    logic [DW:0]       shifted [NUM_EDGES];
    logic [NUM_EDGES-1:0] ge;

    if (k == 0) begin : g_head
      always_comb begin
        src_valid = in_valid;
        src_ctl = in_ctl;
        src_side = in_side;
        for (int l = 0; l < NUM_EDGES; l++) begin
          src_rem[l] = in_rem[l];
          src_den[l] = in_den[l];
          src_quo[l] = '0;
        end
      end
    end else begin : g_tail
      always_comb begin
        src_valid = st_valid[k-1];
        src_ctl = st_ctl[k-1];
        src_side = st_side[k-1];
        for (int l = 0; l < NUM_EDGES; l++) begin
          src_rem[l] = st_rem[k-1][l];
          src_den[l] = st_den[k-1][l];
          src_quo[l] = st_quo[k-1][l];
        end
      end
    end

    // remainder stays below the divisor, so the doubled value fits one extra bit
    always_comb begin
      for (int l = 0; l < NUM_EDGES; l++) begin
        shifted[l] = {src_rem[l], 1'b0};
        ge[l] = shifted[l] >= {1'b0, src_den[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (advance) begin
        st_valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st_ctl[k] <= src_ctl;
        st_side[k] <= src_side;
        for (int l = 0; l < NUM_EDGES; l++) begin
          st_rem[k][l] <= ge[l] ? DW'(shifted[l] - {1'b0, src_den[l]}) : shifted[l][DW-1:0];
          st_den[k][l] <= src_den[l];
          st_quo[k][l] <= {src_quo[l][T_FRAC-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = st_valid[T_FRAC-1];
  assign out_ctl   = st_ctl[T_FRAC-1];
  assign out_side  = st_side[T_FRAC-1];

  always_comb begin
    for (int l = 0; l < NUM_EDGES; l++) begin
      out_quo[l] = st_quo[T_FRAC-1][l];
      out_rem_nz[l] = st_rem[T_FRAC-1][l] != '0;
    end
  end

  for (genvar l = 0; l < NUM_EDGES; l++) begin : g_chk
    `CWSC_ASSERT_IMP(a_rem_below_den, clk, rst, out_valid && !out_ctl.edges[l].over,
      st_rem[T_FRAC-1][l] < st_den[T_FRAC-1][l], "divider remainder not below divisor")
  end

endmodule

/* src/cwsc_interp.sv */
// back stages: entry and exit parameters, endpoint interpolation, result register
module cwsc_interp #(
  parameter int COORD_WIDTH = 32,
  localparam int BASE_W = (COORD_WIDTH > 32) ? COORD_WIDTH : 32,
  localparam int XW = BASE_W + 2,
  localparam int DW = XW + 1,
  localparam int SIDE_W = 2 * XW + 2 * DW,
  localparam int HI_W = DW - 32,
  localparam int PLO_W = 32 + cwsc_pkg::T_W,
  localparam int PHI_W = HI_W + cwsc_pkg::T_W + 1,
  localparam int PROD_W = DW + cwsc_pkg::T_W + 1,
  localparam int OFS_W = PROD_W - cwsc_pkg::T_FRAC,
  localparam int SUM_W = OFS_W + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  cwsc_pkg::item_ctl_t               in_ctl,
  input  logic [cwsc_pkg::T_FRAC-1:0]       in_quo [cwsc_pkg::NUM_EDGES],
  input  logic [cwsc_pkg::NUM_EDGES-1:0]    in_rem_nz,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic signed [COORD_WIDTH-1:0]     out_coord [cwsc_pkg::NUM_COORDS],
  output cwsc_pkg::status_t                 out_status
);
  import cwsc_pkg::*;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (T_FRAC - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // stage 1: pick the largest entry and smallest exit parameter
  logic [T_W-1:0] te_c, tx_c;
  logic           bad_c;

  always_comb begin
    logic [T_W-1:0] t_ent;
    logic [T_W-1:0] t_lv;
    te_c = '0;
    tx_c = T_ONE;
    bad_c = 1'b0;
    for (int l = 0; l < NUM_EDGES; l++) begin
      t_ent = in_ctl.edges[l].over ? (in_ctl.edges[l].equal ? T_ONE : T_SAT)
                                   : (T_W'(in_quo[l]) + T_W'(in_rem_nz[l]));
      t_lv  = in_ctl.edges[l].over ? T_ONE : T_W'(in_quo[l]);
      if (in_ctl.edges[l].entry && (t_ent > te_c)) begin
        te_c = t_ent;
      end
      if (in_ctl.edges[l].leave && (t_lv < tx_c)) begin
        tx_c = t_lv;
      end
      bad_c = bad_c | in_ctl.edges[l].bad;
    end
  end

  logic              t1_valid, t1_bad, t1_nc;
  logic [T_W-1:0]    t1_te, t1_tx;
  logic [SIDE_W-1:0] t1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (advance) begin
      t1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t1_te <= te_c;
      t1_tx <= tx_c;
      t1_bad <= bad_c;
      t1_nc <= in_ctl.not_cyl;
      t1_side <= in_side;
    end
  end

  // stage 2: split products, low 32 bits and signed high part
  logic [XW-1:0]  x0, y0;
  logic [DW-1:0]  dx, dy;
  logic [DW-1:0]  d_sel [NUM_COORDS];
  logic [T_W-1:0] t_sel [NUM_COORDS];
  logic [XW-1:0]  b_sel [NUM_COORDS];

  assign x0 = t1_side[SIDE_W-1 -: XW];
  assign y0 = t1_side[SIDE_W-XW-1 -: XW];
  assign dx = t1_side[2*DW-1 -: DW];
  assign dy = t1_side[DW-1:0];

  // start r-phi, start z, end r-phi, end z
  always_comb begin
    d_sel[0] = dx; t_sel[0] = t1_te; b_sel[0] = x0;
    d_sel[1] = dy; t_sel[1] = t1_te; b_sel[1] = y0;
    d_sel[2] = dx; t_sel[2] = t1_tx; b_sel[2] = x0;
    d_sel[3] = dy; t_sel[3] = t1_tx; b_sel[3] = y0;
  end

  logic                    t2_valid, t2_out, t2_nc;
  logic [PLO_W-1:0]        t2_plo  [NUM_COORDS];
  logic signed [PHI_W-1:0] t2_phi  [NUM_COORDS];
  logic [XW-1:0]           t2_base [NUM_COORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else if (advance) begin
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t2_out <= t1_bad || (t1_te > t1_tx);
      t2_nc <= t1_nc;
      for (int k = 0; k < NUM_COORDS; k++) begin
        t2_plo[k] <= PLO_W'(d_sel[k][31:0]) * PLO_W'(t_sel[k]);
        t2_phi[k] <= PHI_W'($signed(d_sel[k][DW-1:32])) * $signed(PHI_W'(t_sel[k]));
        t2_base[k] <= b_sel[k];
      end
    end
  end

  // stage 3: combine partial products, round half up, drop the t fraction
  logic [PROD_W-1:0] prod [NUM_COORDS];

  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      prod[k] = (PROD_W'(t2_phi[k]) << 32) + PROD_W'(t2_plo[k]) + ROUND_HALF;
    end
  end

  logic                    t3_valid, t3_out, t3_nc;
  logic signed [OFS_W-1:0] t3_ofs  [NUM_COORDS];
  logic [XW-1:0]           t3_base [NUM_COORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_valid <= 1'b0;
    end else if (advance) begin
      t3_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t3_out <= t2_out;
      t3_nc <= t2_nc;
      for (int k = 0; k < NUM_COORDS; k++) begin
        t3_ofs[k] <= prod[k][PROD_W-1:T_FRAC];
        t3_base[k] <= t2_base[k];
      end
    end
  end

  // stage 4: add to start point, saturate, result register
  logic signed [SUM_W-1:0]       sum [NUM_COORDS];
  logic signed [COORD_WIDTH-1:0] sat [NUM_COORDS];

  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      sum[k] = SUM_W'($signed(t3_base[k])) + SUM_W'(t3_ofs[k]);
      if (sum[k] > SAT_HI) begin
        sat[k] = SAT_HI[COORD_WIDTH-1:0];
      end else if (sum[k] < SAT_LO) begin
        sat[k] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        sat[k] = sum[k][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= t3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NUM_COORDS; k++) begin
        out_coord[k] <= (t3_nc || t3_out) ? '0 : sat[k];
      end
      if (t3_nc) begin
        out_status <= STATUS_NOT_CYL;
      end else if (t3_out) begin
        out_status <= STATUS_OUTSIDE;
      end else begin
        out_status <= STATUS_OK;
      end
    end
  end

endmodule

/* src/cylinder_window_segment_clipper_core.sv */
// Segment clipper against a cylinder window in the (r-phi, z) plane.
//
// Input channel: in_valid / in_stall with start_rphi, start_z, end_rphi, end_z
// (signed fixed point, 16 fraction bits). Output channel: out_valid /
// out_stall with the four clipped coordinates and status (ok, wholly outside,
// surface not cylindrical). Non-ok results carry zero coordinates.
// Configuration: cfg_valid / cfg_ready, cfg_index picks the register, cfg_data
// holds the value; cfg_ready is always high. Write only while the block is idle.
//
// The path from input accept to result valid runs through 26 register
// stages: 6 setup stages (capture, two unwrap steps, edge terms, classify,
// compare), 16 divider stages producing one quotient bit each, and 4 back stages
// (parameter select, split multiply, round, add and saturate). One item enters per
// cycle while in_stall is low. When out_stall holds a valid result, every stage
// holds and in_stall rises; empty output lets the pipe move on regardless of out_stall.
// Reset (rst, synchronous) empties the pipe and loads register defaults:
// all zero except bounds_are_cylinder set.
`include "cylinder_window_segment_clipper_core_macros.svh"
module cylinder_window_segment_clipper_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       start_rphi,
  input  logic signed [COORD_WIDTH-1:0]       start_z,
  input  logic signed [COORD_WIDTH-1:0]       end_rphi,
  input  logic signed [COORD_WIDTH-1:0]       end_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]       clipped_start_rphi,
  output logic signed [COORD_WIDTH-1:0]       clipped_start_z,
  output logic signed [COORD_WIDTH-1:0]       clipped_end_rphi,
  output logic signed [COORD_WIDTH-1:0]       clipped_end_z,
  output logic [1:0]                          status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cwsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cwsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cwsc_pkg::*;

  localparam int BASE_W = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int XW = BASE_W + 2;
  localparam int DW = XW + 1;
  localparam int SIDE_W = 2 * XW + 2 * DW;

  cfg_t cfg;
  logic advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  cwsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic              su_valid;
  item_ctl_t         su_ctl;
  logic [DW-1:0]     su_rem [NUM_EDGES];
  logic [DW-1:0]     su_den [NUM_EDGES];
  logic [SIDE_W-1:0] su_side;

  cwsc_setup #(.COORD_WIDTH(COORD_WIDTH)) u_setup (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (in_valid),
    .start_rphi (start_rphi),
    .start_z    (start_z),
    .end_rphi   (end_rphi),
    .end_z      (end_z),
    .cfg        (cfg),
    .out_valid  (su_valid),
    .out_ctl    (su_ctl),
    .out_rem    (su_rem),
    .out_den    (su_den),
    .out_side   (su_side)
  );

  logic                 dv_valid;
  item_ctl_t            dv_ctl;
  logic [T_FRAC-1:0]    dv_quo [NUM_EDGES];
  logic [NUM_EDGES-1:0] dv_rem_nz;
  logic [SIDE_W-1:0]    dv_side;

  cwsc_div_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (su_valid),
    .in_ctl     (su_ctl),
    .in_rem     (su_rem),
    .in_den     (su_den),
    .in_side    (su_side),
    .out_valid  (dv_valid),
    .out_ctl    (dv_ctl),
    .out_quo    (dv_quo),
    .out_rem_nz (dv_rem_nz),
    .out_side   (dv_side)
  );

  logic signed [COORD_WIDTH-1:0] coord [NUM_COORDS];
  status_t                       res_status;

  cwsc_interp #(.COORD_WIDTH(COORD_WIDTH)) u_interp (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (dv_valid),
    .in_ctl     (dv_ctl),
    .in_quo     (dv_quo),
    .in_rem_nz  (dv_rem_nz),
    .in_side    (dv_side),
    .out_valid  (out_valid),
    .out_coord  (coord),
    .out_status (res_status)
  );

  assign clipped_start_rphi = coord[0];
  assign clipped_start_z    = coord[1];
  assign clipped_end_rphi   = coord[2];
  assign clipped_end_z      = coord[3];
  assign status             = res_status;

  `CWSC_ASSERT_IMP(a_backpressure, clk, rst, out_valid && out_stall, in_stall,
    "input taken while a result is held")
  `CWSC_ASSERT_IMP(a_status_code, clk, rst, out_valid,
    (status == STATUS_OK) || (status == STATUS_OUTSIDE) || (status == STATUS_NOT_CYL),
    "unknown status code")
  `CWSC_ASSERT_IMP(a_reject_zero, clk, rst, out_valid && (status != STATUS_OK),
    (clipped_start_rphi == '0) && (clipped_start_z == '0) &&
    (clipped_end_rphi == '0) && (clipped_end_z == '0),
    "rejected item carries coordinates")

endmodule
